/* hdl/pese_pkg.sv */
// ----------------------------------------------------------------------------
// pese_pkg
// Shared types and character codes for the prefix expression evaluator.
// ----------------------------------------------------------------------------
package pese_pkg;

    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_POW  = 8'h5E;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // ALU operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } alu_op_t;

    // ALU status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zdiv;
    } alu_stat_t;

endpackage

/* hdl/pese_alu.sv */
// ----------------------------------------------------------------------------
// pese_alu
// Shared iterative arithmetic unit: add, subtract, multiply, restoring
// divide (one quotient bit a cycle) and square-and-multiply power (one
// exponent bit per two multiply steps).
// ----------------------------------------------------------------------------
module pese_alu
    import pese_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  alu_op_t                op,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic [VALUE_WIDTH-1:0] result,
    output alu_stat_t              stat
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam logic [VALUE_WIDTH-1:0] ONE  = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] ONES = '1;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_PMUL = 4'b0100,
        A_PSQR = 4'b1000
    } astate_t;

    astate_t                state_reg, state_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;     // result / quotient / power
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;     // remainder / base
    logic [VALUE_WIDTH-1:0] opb_reg, opb_next;     // divisor mag / exponent
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic                   zdiv_reg, zdiv_next;

    logic [VALUE_WIDTH-1:0] mag_a, mag_b, mul_x, mul_y, mul_p;
    logic [VALUE_WIDTH:0]   trial;

    assign mag_a = a[VALUE_WIDTH-1] ? (~a + ONE) : a;
    assign mag_b = b[VALUE_WIDTH-1] ? (~b + ONE) : b;
    // single shared multiplier
    assign mul_p = VALUE_WIDTH'(mul_x * mul_y);
    assign trial = {rem_reg, acc_reg[VALUE_WIDTH-1]} - {1'b0, opb_reg};

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        opb_next   = opb_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        zdiv_next  = zdiv_reg;
        mul_x      = a;
        mul_y      = b;
        case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    zdiv_next = 1'b0;
                    case (op)
                        OP_ADD: begin acc_next = a + b; done_next = 1'b1; end
                        OP_SUB: begin acc_next = a - b; done_next = 1'b1; end
                        OP_MUL: begin acc_next = mul_p; done_next = 1'b1; end
                        OP_DIV:
                        begin
                            if (b == '0)
                            begin
                                acc_next  = '0;
                                zdiv_next = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next   = mag_a;
                                rem_next   = '0;
                                opb_next   = mag_b;
                                neg_next   = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                                cnt_next   = CW'(VALUE_WIDTH);
                                state_next = A_DIV;
                            end
                        end
                        OP_POW:
                        begin
                            if (b[VALUE_WIDTH-1])
                            begin
                                done_next = 1'b1;
                                if (a == '0)
                                begin
                                    acc_next  = '0;
                                    zdiv_next = 1'b1;
                                end
                                else if (a == ONE)
                                    acc_next = ONE;
                                else if (a == ONES)
                                    acc_next = b[0] ? ONES : ONE;
                                else
                                    acc_next = '0;
                            end
                            else if (b == '0)
                            begin
                                acc_next  = ONE;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                acc_next   = ONE;
                                rem_next   = a;
                                opb_next   = b;
                                state_next = A_PMUL;
                            end
                        end
                        default: begin acc_next = '0; done_next = 1'b1; end
                    endcase
                end
            end
            // one restoring quotient bit per cycle
            A_DIV:
            begin
                if (!trial[VALUE_WIDTH])
                    rem_next = trial[VALUE_WIDTH-1:0];
                else
                    rem_next = {rem_reg[VALUE_WIDTH-2:0], acc_reg[VALUE_WIDTH-1]};
                acc_next = {acc_reg[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (neg_reg)
                        acc_next = ~{acc_reg[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]} + ONE;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            // multiply result by base when exponent bit is set
            A_PMUL:
            begin
                mul_x = acc_reg;
                mul_y = rem_reg;
                if (opb_reg[0])
                    acc_next = mul_p;
                opb_next = opb_reg >> 1;
                if ((opb_reg >> 1) == '0)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                    state_next = A_PSQR;
            end
            // square the base
            A_PSQR:
            begin
                mul_x      = rem_reg;
                mul_y      = rem_reg;
                rem_next   = mul_p;
                state_next = A_PMUL;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            zdiv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            zdiv_reg  <= zdiv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        opb_reg <= opb_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign result    = acc_reg;
    assign stat.busy = (state_reg != A_IDLE);
    assign stat.done = done_reg;
    assign stat.zdiv = zdiv_reg;

endmodule

/* hdl/prefix_expression_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_top
// Prefix expression evaluator: operand stack in RAM, sequencer, shared ALU.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (symbol, expr_end; valid/ready) takes one character per
//   item, last character first; expr_end marks the expression's first
//   character. An item with expr_end produces one result item on the
//   output channel (value and three error flags); others produce none.
//   A digit item is pushed directly; an operator pops two operands and
//   runs the shared ALU, where division forms one quotient bit a cycle
//   and power uses square and multiply, one multiply per cycle. An end
//   item adds a final stack pop that forms the result.
//   The stack is a RAM with registered read; each pop reads through that
//   register. Stack contents have no reset; only the count clears.
//   Reset clears count, flags and the sequencer. One item is worked on at
//   a time; in_ready is low meanwhile. A result waits in the output
//   register while the receiver stalls and the block holds until taken.
// ----------------------------------------------------------------------------
module prefix_expression_stack_evaluator_top
    import pese_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         symbol,
    input  logic               expr_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic               underflow_seen,
    output logic               overflow_seen,
    output logic               zero_divide_seen
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NW = $clog2(STACK_DEPTH + 1);
    localparam logic [VALUE_WIDTH-1:0] ONES = '1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_POPA  = 10'b0000000010,
        S_POPB  = 10'b0000000100,
        S_GETB  = 10'b0000001000,
        S_ALU   = 10'b0000010000,
        S_WAIT  = 10'b0000100000,
        S_PUSH  = 10'b0001000000,
        S_POPR  = 10'b0010000000,
        S_GETR  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NW-1:0]          cnt_reg, cnt_next;
    logic [2:0]             flags_reg, flags_next;     // {zdiv, over, under}
    logic [7:0]             sym_reg;
    logic                   end_reg;
    logic [VALUE_WIDTH-1:0] a_reg, a_next, b_reg, b_next, r_reg, r_next;
    logic                   a_ok_reg, a_ok_next, b_ok_reg, b_ok_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_reg;
    logic                   we, re;
    logic [AW-1:0]          waddr, raddr;
    logic                   is_op;
    alu_op_t                op;
    logic                   alu_start;
    logic [VALUE_WIDTH-1:0] alu_res;
    alu_stat_t              alu_stat;

    assign is_op = (sym_reg == CH_ADD) || (sym_reg == CH_SUB) || (sym_reg == CH_MUL)
                || (sym_reg == CH_DIV) || (sym_reg == CH_POW);

    always_comb
    begin
        case (sym_reg)
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            default: op = OP_POW;
        endcase
    end

    pese_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (op),
        .a      (a_reg),
        .b      (b_reg),
        .result (alu_res),
        .stat   (alu_stat)
    );

    // stack RAM, registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= r_reg;
        if (re)
            rd_reg <= mem[raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        flags_next     = flags_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        a_ok_next      = a_ok_reg;
        b_ok_next      = b_ok_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = cnt_reg[AW-1:0];
        raddr          = AW'(cnt_reg - NW'(1));
        alu_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_POPA;
            end
            // first action: read the top or form the digit value
            S_POPA:
            begin
                if (is_op)
                begin
                    if (cnt_reg == '0)
                    begin
                        flags_next[0] = 1'b1;
                        a_ok_next     = 1'b0;
                    end
                    else
                    begin
                        re        = 1'b1;
                        a_ok_next = 1'b1;
                        cnt_next  = cnt_reg - NW'(1);
                    end
                    state_next = S_POPB;
                end
                else
                begin
                    r_next     = VALUE_WIDTH'($signed({1'b0, sym_reg}) - 9'sd48);
                    state_next = S_PUSH;
                end
            end
            S_POPB:
            begin
                a_next = a_ok_reg ? rd_reg : ONES;
                if (cnt_reg == '0)
                begin
                    flags_next[0] = 1'b1;
                    b_ok_next     = 1'b0;
                end
                else
                begin
                    re        = 1'b1;
                    b_ok_next = 1'b1;
                    cnt_next  = cnt_reg - NW'(1);
                end
                state_next = S_GETB;
            end
            S_GETB:
            begin
                b_next     = b_ok_reg ? rd_reg : ONES;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                alu_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                begin
                    r_next = alu_res;
                    if (alu_stat.zdiv)
                        flags_next[2] = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (cnt_reg >= NW'(STACK_DEPTH))
                    flags_next[1] = 1'b1;
                else
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + NW'(1);
                end
                state_next = end_reg ? S_POPR : S_IDLE;
            end
            S_POPR:
            begin
                if (cnt_reg == '0)
                begin
                    flags_next[0] = 1'b1;
                    a_ok_next     = 1'b0;
                end
                else
                begin
                    re        = 1'b1;
                    a_ok_next = 1'b1;
                    cnt_next  = cnt_reg - NW'(1);
                end
                state_next = S_GETR;
            end
            S_GETR:
            begin
                r_next         = a_ok_reg ? rd_reg : ONES;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    flags_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sym_reg <= symbol;
            end_reg <= expr_end;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        a_ok_reg <= a_ok_next;
        b_ok_reg <= b_ok_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign value            = 32'($signed(r_reg));
    assign underflow_seen   = flags_reg[0];
    assign overflow_seen    = flags_reg[1];
    assign zero_divide_seen = flags_reg[2];

endmodule

/* hdl/pese_checker.sv */
// ----------------------------------------------------------------------------
// pese_checker
// Port-level checks for the prefix expression evaluator.
// ----------------------------------------------------------------------------
module pese_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic        underflow_seen
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result changed while stalled");

    // no new item while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // in_ready drops after an item is accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    // result appears only after an item was taken
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result without work");

    // the underflow flag only changes with a result or while busy
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !$past(out_valid) |-> $stable(underflow_seen))
        else $error("flag changed while idle");

endmodule

bind prefix_expression_stack_evaluator_top pese_checker u_pese_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .underflow_seen (underflow_seen)
);

/* test/tb_prefix_expression_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// tb_prefix_expression_stack_evaluator_top
// Self-checking bench for the prefix evaluator. Characters are sent last to
// first, and a predictor with its own operand stack computes each result
// when its end item is accepted. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_prefix_expression_stack_evaluator_top;
    import pese_pkg::*;

    localparam int DEPTH = 128;

    typedef struct packed {
        logic [31:0] val;
        logic        under;
        logic        over;
        logic        zdiv;
    } eval_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        symbol;
    logic              expr_end;
    logic              out_valid;
    logic              out_ready;
    logic signed [31:0] value;
    logic              underflow_seen;
    logic              overflow_seen;
    logic              zero_divide_seen;

    // predictor state
    logic [31:0]  pred_stack [DEPTH];
    int           pred_count;
    logic [2:0]   pred_flags;   // {zdiv, over, under}
    eval_result_t result_queue [$];

    int  mismatch_count;
    int  results_seen;
    int  items_sent;
    int  idle_pct;

    prefix_expression_stack_evaluator_top #(
        .STACK_DEPTH(DEPTH),
        .VALUE_WIDTH(32)
    ) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .symbol           (symbol),
        .expr_end         (expr_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .value            (value),
        .underflow_seen   (underflow_seen),
        .overflow_seen    (overflow_seen),
        .zero_divide_seen (zero_divide_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] stack_pop();
        if (pred_count == 0)
        begin
            pred_flags[0] = 1'b1;
            return 32'hFFFF_FFFF;
        end
        pred_count--;
        return pred_stack[pred_count];
    endfunction

    function automatic void stack_push(logic [31:0] v);
        if (pred_count >= DEPTH)
            pred_flags[1] = 1'b1;
        else
        begin
            pred_stack[pred_count] = v;
            pred_count++;
        end
    endfunction

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        if (b == 0)
        begin
            pred_flags[2] = 1'b1;
            return 32'd0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] modular_power(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        logic [31:0] base;
        logic [31:0] e;
        r = 32'd1;
        base = a;
        e = b;
        if (b[31])
        begin
            if (a == 0)
            begin
                pred_flags[2] = 1'b1;
                return 32'd0;
            end
            if (a == 1)
                return 32'd1;
            if (a == 32'hFFFF_FFFF)
                return b[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (e != 0)
        begin
            if (e[0])
                r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic void predict_item(logic [7:0] sym, logic last);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        eval_result_t res;
        if (sym == CH_ADD || sym == CH_SUB || sym == CH_MUL || sym == CH_DIV
            || sym == CH_POW)
        begin
            a = stack_pop();
            b = stack_pop();
            case (sym)
                CH_ADD:  r = a + b;
                CH_SUB:  r = a - b;
                CH_MUL:  r = a * b;
                CH_DIV:  r = signed_quotient(a, b);
                default: r = modular_power(a, b);
            endcase
            stack_push(r);
        end
        else
            stack_push({24'd0, sym} - {24'd0, CH_ZERO});
        if (last)
        begin
            res.val   = stack_pop();
            res.under = pred_flags[0];
            res.over  = pred_flags[1];
            res.zdiv  = pred_flags[2];
            pred_flags = 3'b000;
            result_queue.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------
    // valid stays high between back-to-back items; it drops only in idle gaps
    task automatic send_item(logic [7:0] sym, logic last);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        expr_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(sym, last);
        items_sent++;
        @(negedge clk);
    endtask

    // send a string in prefix order, feeding it back to front
    task automatic send_expression(string s);
        for (int i = s.len() - 1; i >= 0; i--)
            send_item(s[i], i == 0);
    endtask

    // random well-formed prefix expression of about n operators
    function automatic string random_expression(int n);
        string ops;
        string s;
        ops = "+-*/^";
        if (n == 0)
        begin
            s = " ";
            s[0] = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0))
                                                : 8'(CH_ZERO + $urandom_range(9, 0));
            return s;
        end
        s = " ";
        s[0] = ops[$urandom_range(4, 0)];
        return {s, random_expression($urandom_range(n - 1, 0)),
                random_expression($urandom_range(n - 1, 0))};
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 results_seen);
        mismatch_count++;
    endtask

    always @(negedge clk)
        if (rst_n)
            out_ready <= (idle_pct == 0) || ($urandom_range(99, 0) >= idle_pct);

    always @(posedge clk)
    begin
        eval_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (result_queue.size() == 0)
                report_mismatch("unexpected result", value, 32'd0);
            else
            begin
                exp_res = result_queue.pop_front();
                if (value !== exp_res.val)
                    report_mismatch("value", value, exp_res.val);
                if (underflow_seen !== exp_res.under)
                    report_mismatch("underflow_seen", underflow_seen, exp_res.under);
                if (overflow_seen !== exp_res.over)
                    report_mismatch("overflow_seen", overflow_seen, exp_res.over);
                if (zero_divide_seen !== exp_res.zdiv)
                    report_mismatch("zero_divide_seen", zero_divide_seen, exp_res.zdiv);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_operators();
        send_expression("+34");
        send_expression("-27");
        send_expression("*96");
        send_expression("/73");
        send_expression("/-073");    // negative dividend truncates toward zero
        send_expression("^23");
        send_expression("^50");      // x to the power zero
        send_expression("^00");      // zero to the power zero
    endtask

    task automatic test_special_cases();
        send_expression("/50");      // divide by zero
        send_expression("^0-01");    // zero to a negative power
        send_expression("^1-01");    // one to a negative power
        send_expression("^-01-03");  // minus one, odd negative exponent
        send_expression("^2-01");    // other base, negative exponent
        send_expression("+");        // pops on an empty stack
        send_item(8'hFF, 1'b0);      // extreme character codes, leftover entry
        send_item(8'h00, 1'b1);
        send_expression("^^^^^99999");  // large power wraps
        // most negative value divided by minus one: -2^31 built as 2^31
        send_expression("/^2+*561-01");
    endtask

    task automatic test_stack_limits();
        // pop leftover, then fill past the top so a push is dropped
        send_expression("+");
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(8'(CH_ZERO + (i % 10)), 1'b0);
        send_item(CH_ADD, 1'b1);
        // drain back to empty, checking underflow on the way out
        while (pred_count > 0)
            send_expression("+");
        send_expression("+");
    endtask

    task automatic test_random(int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
            else
                send_expression(random_expression($urandom_range(6, 0)));
            if (pred_count > DEPTH - 16)
                while (pred_count > 2)
                    send_expression("+");
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        symbol = 8'd0;
        expr_end = 1'b0;
        out_ready = 1'b0;
        mismatch_count = 0;
        results_seen = 0;
        items_sent = 0;
        pred_count = 0;
        pred_flags = 3'b000;
        idle_pct = 24;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_operators();
        test_special_cases();
        idle_pct = 0;
        test_stack_limits();
        test_random(300);
        idle_pct = 24;
        test_random(1150);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (result_queue.size() > 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        $display("Sent %0d characters, checked %0d results (operators, stack limits,",
                 items_sent, results_seen);
        $display("error flags and random prefix expressions).");
        if (mismatch_count == 0 && result_queue.size() == 0)
            $display("[prefix_expression_stack_evaluator_top] OK");
        else
            $display("[prefix_expression_stack_evaluator_top] ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout");
        $display("[prefix_expression_stack_evaluator_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/pese_pkg.sv
hdl/pese_alu.sv
hdl/prefix_expression_stack_evaluator_top.sv
hdl/pese_checker.sv
test/tb_prefix_expression_stack_evaluator_top.sv
